/* design/csvg_pkg.sv */
// Shared constants, types and the face corner table of the cube sphere vertex generator.
package csvg_pkg;

  localparam int unsigned MAX_SUBDIVISION = 6;

  localparam int unsigned EDGE_W = 15;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned FACE_W = 3;
  localparam int unsigned GRID_W = 7;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned TEX_W  = 17;
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned SUM_W  = 14;
  localparam int unsigned ROOT_W = 23;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned QUO_W  = 22;
  localparam int unsigned NUM_W  = ROOT_W + QUO_W;
  localparam int unsigned EM_W   = 22;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned SIDE_N = ROOT_W + QUO_W;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 160;

  localparam logic [LVL_W-1:0]  MAX_LEVEL  = LVL_W'(MAX_SUBDIVISION);
  localparam logic [EDGE_W-1:0] EDGE_RESET = 15'd256;
  localparam logic [NRM_W-1:0]  ONE_Q14    = 16'd16384;

  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;

  localparam logic [IDX_W-1:0] REG_EDGE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LEVEL  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SPHERE = 2'd2;

  typedef struct packed {
    logic                        bad;
    logic                        sph;
    logic [LVL_W-1:0]            lvl;
    logic [2:0]                  neg;
    logic [2:0]                  fix;
    logic [2:0][GRID_W-1:0]      mag;
    logic [2:0][EM_W-1:0]        em;
    logic [TEX_W-1:0]            tex_u;
    logic [TEX_W-1:0]            tex_v;
  } side_t;

  // Negative-sign bits per corner {bottom-left, top-right, top-left}, each {z, y, x}.
  function automatic logic [2:0][2:0] corner_neg(input logic [FACE_W-1:0] face);
    logic [2:0][2:0] r;
    case (face)
      FACE_FRONT:  r = {3'b011, 3'b000, 3'b001};
      FACE_BACK:   r = {3'b110, 3'b101, 3'b100};
      FACE_LEFT:   r = {3'b111, 3'b001, 3'b101};
      FACE_RIGHT:  r = {3'b010, 3'b100, 3'b000};
      FACE_BOTTOM: r = {3'b111, 3'b010, 3'b011};
      FACE_TOP:    r = {3'b001, 3'b100, 3'b101};
      default:     r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/csvg_sqrt.sv */
// Pipelined integer square root of a sum shifted up by 32 bits, one result bit per stage.
module csvg_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [csvg_pkg::SUM_W-1:0]  sum_i,
  output logic [csvg_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned RW    = csvg_pkg::ROOT_W;
  localparam int unsigned AW    = csvg_pkg::RAD_W;
  localparam int unsigned REM_W = RW + 2;

  logic [REM_W-1:0] rem_q  [RW-1];
  logic [AW-1:0]    rad_q  [RW-1];
  logic [RW-1:0]    root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [AW-1:0]    rad_in;
    logic [RW-1:0]    root_in;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {sum_i, {(AW - csvg_pkg::SUM_W){1'b0}}};
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign rem_sh = {rem_in, rad_in[AW-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= {root_in[RW-2:0], ge};
      end
    end

    if (i < RW - 1) begin : g_carry
      logic [REM_W+1:0] rem_nx;
      assign rem_nx = ge ? rem_sh - trial : rem_sh;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= rem_nx[REM_W-1:0];
          rad_q[i] <= {rad_in[AW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

/* design/csvg_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module csvg_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [csvg_pkg::NUM_W-1:0]  num_i,
  input  logic [csvg_pkg::ROOT_W-1:0] den_i,
  output logic [csvg_pkg::QUO_W-1:0]  quo_o
);

  localparam int unsigned DW = csvg_pkg::ROOT_W;
  localparam int unsigned QW = csvg_pkg::QUO_W;

  logic [DW-1:0] rem_q [QW-1];
  logic [QW-1:0] low_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   t;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = num_i[csvg_pkg::NUM_W-1 -: DW];
      assign low_in = num_i[QW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign t  = {rem_in, low_in[QW-1]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[i] <= {quo_in[QW-2:0], ge};
      end
    end

    if (i < QW - 1) begin : g_carry
      logic [DW:0] t_nx;
      assign t_nx = ge ? t - {1'b0, den_in} : t;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= t_nx[DW-1:0];
          low_q[i] <= {low_in[QW-2:0], 1'b0};
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* design/cube_sphere_vertex_generator.sv */
// Top level: cube and sphere vertex generation pipeline with stream ports.
// Pipeline stages: one each for grid, scaling and output, 23 for the square root, 22 for the dividers.
// Throughput: one item per cycle; a stalled output freezes every stage at once.
// Reset clears all valid bits and loads edge 1.0, level 0, cube mode.
// Configuration writes are taken every cycle.
module cube_sphere_vertex_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [csvg_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [csvg_pkg::EDGE_W-1:0]          cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // face [2:0], row [9:3], col [16:10]
  input  logic [csvg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pos_x [23:0], pos_y [47:24], pos_z [71:48], tex_u [88:72], tex_v [105:89],
  // norm_x [121:106], norm_y [137:122], norm_z [153:138]
  output logic [csvg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // bad_request [0]
  output logic [0:0]                           m_axis_tuser
);

  localparam int unsigned GW = csvg_pkg::GRID_W;
  localparam int unsigned SN = csvg_pkg::SIDE_N;
  localparam int unsigned RW = csvg_pkg::ROOT_W;

  logic [csvg_pkg::EDGE_W-1:0] edge_q;
  logic [csvg_pkg::LVL_W-1:0]  level_q;
  logic                        sphere_q;

  logic en;

  logic                         in_vld_q;
  logic [csvg_pkg::FACE_W-1:0]  face_q;
  logic [GW-1:0]                row_q;
  logic [GW-1:0]                col_q;

  csvg_pkg::side_t a_d, a_q, b_d, b_q;
  logic            a_vld_q, b_vld_q;
  logic [csvg_pkg::SUM_W-1:0] sum_d, sum_q;

  csvg_pkg::side_t side_q [SN];
  logic [SN-1:0]   vld_q;

  logic [RW-1:0]                root;
  logic [csvg_pkg::QUO_W-1:0]   pquo [3];
  logic [csvg_pkg::QUO_W-1:0]   nquo [3];
  logic [csvg_pkg::NUM_W-1:0]   pnum [3];
  logic [csvg_pkg::NUM_W-1:0]   nnum [3];

  logic [csvg_pkg::LVL_W-1:0]   lvl;
  logic [GW-1:0]                n;
  logic [2:0][2:0]              cn;
  logic signed [9:0]            sv [3];
  logic signed [9:0]            n10, col2, row2;

  csvg_pkg::side_t              sd;
  logic [GW-1:0]                nhalf;
  logic [28:0]                  hp [3];
  logic [28:0]                  hp_sh [3];
  logic [csvg_pkg::POS_W-1:0]   pmag [3];
  logic [csvg_pkg::POS_W-1:0]   pos [3];
  logic [csvg_pkg::NRM_W-1:0]   nrm [3];

  logic                               out_vld_q;
  logic [csvg_pkg::OUT_TDATA_W-1:0]   out_data_d, out_data_q;
  logic                               out_bad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= csvg_pkg::EDGE_RESET;
      level_q  <= '0;
      sphere_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csvg_pkg::REG_EDGE:   edge_q   <= cfg_data_i;
        csvg_pkg::REG_LEVEL:  level_q  <= cfg_data_i[csvg_pkg::LVL_W-1:0];
        csvg_pkg::REG_SPHERE: sphere_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Global valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= s_axis_tvalid;
      a_vld_q   <= in_vld_q;
      b_vld_q   <= a_vld_q;
      vld_q     <= {vld_q[SN-2:0], b_vld_q};
      out_vld_q <= vld_q[SN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      face_q <= s_axis_tdata[2:0];
      row_q  <= s_axis_tdata[9:3];
      col_q  <= s_axis_tdata[16:10];
    end
  end

  // Grid coordinates, range check, texture coordinates.
  always_comb begin
    lvl  = (level_q > csvg_pkg::MAX_LEVEL) ? csvg_pkg::MAX_LEVEL : level_q;
    n    = GW'(1) << lvl;
    cn   = csvg_pkg::corner_neg(face_q);
    n10  = 10'(n);
    col2 = 10'({col_q, 1'b0});
    row2 = 10'({row_q, 1'b0});
    a_d       = '0;
    a_d.bad   = (face_q > csvg_pkg::FACE_TOP) || (row_q > n) || (col_q > n);
    a_d.sph   = sphere_q;
    a_d.lvl   = lvl;
    a_d.tex_u = csvg_pkg::TEX_W'(col_q) << (5'd16 - 5'(lvl));
    a_d.tex_v = csvg_pkg::TEX_W'(row_q) << (5'd16 - 5'(lvl));
    for (int a = 0; a < 3; a++) begin
      sv[a] = cn[0][a] ? -n10 : n10;
      if (cn[1][a] != cn[0][a]) begin
        sv[a] = cn[1][a] ? sv[a] - col2 : sv[a] + col2;
      end
      if (cn[2][a] != cn[0][a]) begin
        sv[a] = cn[2][a] ? sv[a] - row2 : sv[a] + row2;
      end
      a_d.neg[a] = sv[a][9];
      a_d.mag[a] = sv[a][9] ? GW'(-sv[a]) : GW'(sv[a]);
      a_d.fix[a] = (cn[1][a] == cn[0][a]) && (cn[2][a] == cn[0][a]);
    end
  end

  // Squared length and edge-scaled magnitudes.
  always_comb begin
    b_d   = a_q;
    sum_d = '0;
    for (int a = 0; a < 3; a++) begin
      b_d.em[a] = csvg_pkg::EM_W'(edge_q) * csvg_pkg::EM_W'(a_q.mag[a]);
      sum_d     = sum_d + csvg_pkg::SUM_W'(a_q.mag[a]) * csvg_pkg::SUM_W'(a_q.mag[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= b_d;
      sum_q <= sum_d;
      side_q[0] <= b_q;
      for (int i = 1; i < SN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  csvg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_q),
    .root_o (root)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign pnum[a] = {side_q[RW-1].em[a], {RW{1'b0}}}
                   + csvg_pkg::NUM_W'(root[RW-1:1]);
    assign nnum[a] = (csvg_pkg::NUM_W'(side_q[RW-1].mag[a]) << 30)
                   + csvg_pkg::NUM_W'(root[RW-1:1]);

    csvg_div u_pdiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (pnum[a]),
      .den_i (root),
      .quo_o (pquo[a])
    );

    csvg_div u_ndiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nnum[a]),
      .den_i (root),
      .quo_o (nquo[a])
    );
  end

  // Select cube or sphere results, apply signs, zero bad requests.
  always_comb begin
    sd    = side_q[SN-1];
    nhalf = (sd.lvl == '0) ? '0 : GW'(1) << (sd.lvl - 3'd1);
    for (int a = 0; a < 3; a++) begin
      hp[a]    = {sd.em[a], 7'd0} + 29'(nhalf);
      hp_sh[a] = hp[a] >> sd.lvl;
      pmag[a]  = sd.sph ? csvg_pkg::POS_W'(pquo[a]) : hp_sh[a][csvg_pkg::POS_W-1:0];
      pos[a]   = sd.neg[a] ? -pmag[a] : pmag[a];
      if (sd.sph) begin
        nrm[a] = sd.neg[a] ? -nquo[a][csvg_pkg::NRM_W-1:0] : nquo[a][csvg_pkg::NRM_W-1:0];
      end else if (sd.fix[a]) begin
        nrm[a] = sd.neg[a] ? -csvg_pkg::ONE_Q14 : csvg_pkg::ONE_Q14;
      end else begin
        nrm[a] = '0;
      end
    end
    if (sd.bad) begin
      out_data_d = '0;
    end else begin
      out_data_d = {6'd0, nrm[2], nrm[1], nrm[0], sd.tex_v, sd.tex_u, pos[2], pos[1], pos[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_bad_q  <= sd.bad;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_bad_q;

endmodule

/* design/csvg_chk.sv */
// Port-level checker for the cube sphere vertex generator, bound to the top level.
module csvg_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [csvg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                       m_axis_tuser
);

  logic signed [csvg_pkg::NRM_W-1:0] nx, ny, nz;

  assign nx = m_axis_tdata[121:106];
  assign ny = m_axis_tdata[137:122];
  assign nz = m_axis_tdata[153:138];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("bad request carries nonzero data");

  a_nrm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (nx >= -16'sd16384) && (nx <= 16'sd16384) &&
                      (ny >= -16'sd16384) && (ny <= 16'sd16384) &&
                      (nz >= -16'sd16384) && (nz <= 16'sd16384))
    else $error("normal component out of unit range");

endmodule

bind cube_sphere_vertex_generator csvg_chk u_csvg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
